/* design/pca_pkg.sv */
package pca_pkg;

    localparam int unsigned PALETTE_SIZE_DEF = 256;
    localparam int unsigned CHAN_W           = 8;
    localparam int unsigned RGB_W            = 3 * CHAN_W;
    localparam int unsigned COMP_W           = 16;
    localparam int unsigned RESULT_W         = 32;
    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic             vld;
        logic             hit;
        logic             ins;
        logic [RGB_W-1:0] rgb;
    } t_token;

    function automatic logic [CHAN_W-1:0] sat_channel(input logic signed [COMP_W-1:0] x);
        logic [CHAN_W-1:0] res;
        if (x[COMP_W-1]) begin
            res = '0;
        end else if (|x[COMP_W-2:CHAN_W]) begin
            res = '1;
        end else begin
            res = x[CHAN_W-1:0];
        end
        return res;
    endfunction

endpackage

/* design/palette_color_allocator.sv */
// Palette mode: the request is registered, walks the chain of palette cells one cell per cycle, and
// the result is registered from the end of the chain; one item is in flight at a time.
// True-color mode: the result is registered and valid in the cycle after acceptance.
// A new item is accepted in the cycle its predecessor's result beat is taken.
// Synchronous active-low reset empties the palette and clears true-color mode.
module palette_color_allocator #(
    parameter int unsigned PALETTE_SIZE = pca_pkg::PALETTE_SIZE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [pca_pkg::COMP_W-1:0] i_red,
    input  logic signed [pca_pkg::COMP_W-1:0] i_green,
    input  logic signed [pca_pkg::COMP_W-1:0] i_blue,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [pca_pkg::RESULT_W-1:0]    o_color_result,
    output logic                            o_was_found,
    output logic                            o_palette_full,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic                            i_cfg_data
);

    localparam int unsigned IDX_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam int unsigned CNT_W = $clog2(PALETTE_SIZE + 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_OUT    = 3'b100
    } t_state;

    t_state                       r_state;
    t_state                       n_state;
    logic                         r_mode;
    logic [CNT_W-1:0]             r_count;
    pca_pkg::t_token              r_inj;
    pca_pkg::t_token              n_inj;
    logic [pca_pkg::RESULT_W-1:0] r_res;
    logic [pca_pkg::RESULT_W-1:0] n_res;
    logic                         r_found;
    logic                         n_found;
    logic                         r_full;
    logic                         n_full;
    logic                         in_fire;
    logic                         out_fire;
    logic [pca_pkg::RGB_W-1:0]    rgb;

    pca_pkg::t_token              tok [PALETTE_SIZE+1];
    logic [IDX_W-1:0]             idx [PALETTE_SIZE+1];

    assign tok[0] = r_inj;
    assign idx[0] = '0;

    for (genvar g = 0; g < PALETTE_SIZE; g++) begin : g_cell
        pca_cell #(
            .IDX   (g),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (tok[g]),
            .i_idx   (idx[g]),
            .i_count (r_count),
            .o_tok   (tok[g+1]),
            .o_idx   (idx[g+1])
        );
    end

    assign rgb = {pca_pkg::sat_channel(i_red), pca_pkg::sat_channel(i_green),
                  pca_pkg::sat_channel(i_blue)};

    assign o_ready     = (r_state == S_IDLE) || ((r_state == S_OUT) && i_ready);
    assign in_fire     = i_valid && o_ready;
    assign out_fire    = (r_state == S_OUT) && i_ready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state   = r_state;
        n_inj     = r_inj;
        n_inj.vld = 1'b0;
        n_res     = r_res;
        n_found   = r_found;
        n_full    = r_full;
        unique case (r_state) inside
            S_IDLE, S_OUT: begin
                if (in_fire) begin
                    if (r_mode) begin
                        n_res   = {pca_pkg::ALPHA_OPAQUE, rgb};
                        n_found = 1'b0;
                        n_full  = 1'b0;
                        n_state = S_OUT;
                    end else begin
                        n_inj.vld = 1'b1;
                        n_inj.hit = 1'b0;
                        n_inj.ins = 1'b0;
                        n_inj.rgb = rgb;
                        n_state   = S_SEARCH;
                    end
                end else if (out_fire) begin
                    n_state = S_IDLE;
                end
            end
            S_SEARCH: begin
                if (tok[PALETTE_SIZE].vld) begin
                    if (tok[PALETTE_SIZE].hit || tok[PALETTE_SIZE].ins) begin
                        n_res = pca_pkg::RESULT_W'(idx[PALETTE_SIZE]);
                    end else begin
                        n_res = '0;
                    end
                    n_found = tok[PALETTE_SIZE].hit;
                    n_full  = !tok[PALETTE_SIZE].hit && !tok[PALETTE_SIZE].ins;
                    n_state = S_OUT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mode    <= 1'b0;
            r_count   <= '0;
            r_inj.vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_inj.vld <= n_inj.vld;
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            if ((r_state == S_SEARCH) && tok[PALETTE_SIZE].vld && tok[PALETTE_SIZE].ins) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
        r_inj.hit <= n_inj.hit;
        r_inj.ins <= n_inj.ins;
        r_inj.rgb <= n_inj.rgb;
        r_res     <= n_res;
        r_found   <= n_found;
        r_full    <= n_full;
    end

    assign o_valid        = (r_state == S_OUT);
    assign o_color_result = r_res;
    assign o_was_found    = r_found;
    assign o_palette_full = r_full;

endmodule

/* design/pca_cell.sv */
module pca_cell #(
    parameter int unsigned IDX   = 0,
    parameter int unsigned IDX_W = 8,
    parameter int unsigned CNT_W = 9
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pca_pkg::t_token      i_tok,
    input  logic [IDX_W-1:0]     i_idx,
    input  logic [CNT_W-1:0]     i_count,
    output pca_pkg::t_token      o_tok,
    output logic [IDX_W-1:0]     o_idx
);

    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [pca_pkg::RGB_W-1:0] r_entry;
    pca_pkg::t_token           r_tok;
    pca_pkg::t_token           n_tok;
    logic [IDX_W-1:0]          r_idx;
    logic [IDX_W-1:0]          n_idx;
    logic                      open;
    logic                      hit_here;
    logic                      ins_here;

    always_comb begin
        open     = i_tok.vld && !i_tok.hit && !i_tok.ins;
        hit_here = open && (MY_CNT < i_count) && (r_entry == i_tok.rgb);
        ins_here = open && (MY_CNT == i_count);
        n_tok     = i_tok;
        n_tok.hit = i_tok.hit | hit_here;
        n_tok.ins = i_tok.ins | ins_here;
        n_idx     = (hit_here || ins_here) ? MY_IDX : i_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok.vld <= n_tok.vld;
        end
        r_tok.hit <= n_tok.hit;
        r_tok.ins <= n_tok.ins;
        r_tok.rgb <= n_tok.rgb;
        r_idx     <= n_idx;
        if (ins_here) begin
            r_entry <= i_tok.rgb;
        end
    end

    assign o_tok = r_tok;
    assign o_idx = r_idx;

endmodule
